[rtl/trhf_pkg.sv]
package trhf_pkg;

  localparam int unsigned ChanW   = 16;
  localparam int unsigned TickW   = 16;
  localparam int unsigned ElecW   = 24;
  localparam int unsigned GainW   = 24;
  localparam int unsigned GainFrac = 8;
  localparam int unsigned ChargeW = 40;
  localparam int unsigned TotalW  = 56;
  localparam int unsigned ThrW    = 40;
  localparam int unsigned ApbAddrW = 4;
  localparam int unsigned ApbDataW = 64;

  localparam logic [GainW-1:0] GainReset = 24'd446;
  localparam logic [ThrW-1:0]  ThrReset  = 40'd1280;

  // Register index as decoded from the APB byte address (8-byte spacing).
  localparam logic RegAdcGain  = 1'b0;
  localparam logic RegMinTotal = 1'b1;

  typedef struct packed {
    logic [ChanW-1:0] channel_id;
    logic [TickW-1:0] tick;
    logic [ElecW-1:0] electrons;
    logic             end_of_channel;
  } tick_item_t;

  typedef struct packed {
    logic [ChanW-1:0]   hit_channel;
    logic [TickW-1:0]   start_tick;
    logic [TickW-1:0]   stop_tick;
    logic [TickW-1:0]   peak_tick;
    logic [ChargeW-1:0] peak_charge_q8;
    logic [TotalW-1:0]  total_charge_q8;
    logic               final_of_step;
  } hit_t;

  typedef struct packed {
    tick_item_t         item;
    logic [ChargeW-1:0] charge;
  } charged_tick_t;

  // Hits produced by one tick: count is 0, 1 or 2, first goes out first.
  typedef struct packed {
    logic [1:0] count;
    hit_t       first;
    hit_t       second;
  } hit_push_t;

endpackage

[rtl/tick_run_hit_finder.sv]
// Channel   Direction  Handshake              Payload
// tick in   input      in_valid_i/in_ready_o  in_item_i (tick_item_t)
// hit out   output     out_valid_o/out_ready_i out_hit_o (hit_t)
// config    input      APB psel/penable/pready paddr, pwdata, prdata (64 bits)
//
// One tick is taken per cycle unless the hit queue is short of room. A tick
// passes an input register and the gain multiplier register, then updates the
// run state, and its hits go into a four-entry hit queue. A tick may give two
// hits; these leave one at a time, which sets the rate when hits are dense.
// Reset clears the open run and loads the register defaults. A stalled output
// backs up the queue and then the two input stages.
module tick_run_hit_finder #(
  parameter int unsigned TICK_BITS = 16
) (
  input  logic                          clk_i,
  input  logic                          rst_ni,
  input  logic                          in_valid_i,
  output logic                          in_ready_o,
  input  trhf_pkg::tick_item_t          in_item_i,
  output logic                          out_valid_o,
  input  logic                          out_ready_i,
  output trhf_pkg::hit_t                out_hit_o,
  input  logic                          psel,
  input  logic                          penable,
  input  logic                          pwrite,
  input  logic [trhf_pkg::ApbAddrW-1:0] paddr,
  input  logic [trhf_pkg::ApbDataW-1:0] pwdata,
  output logic [trhf_pkg::ApbDataW-1:0] prdata,
  output logic                          pready
);
  import trhf_pkg::*;

  logic [GainW-1:0] gain;
  logic [ThrW-1:0]  min_total;
  logic             ch_valid, ch_ready;
  charged_tick_t    ch_item;
  logic             room;
  hit_push_t        push;

  trhf_regs u_regs (
    .clk_i       (clk_i),
    .rst_ni      (rst_ni),
    .psel        (psel),
    .penable     (penable),
    .pwrite      (pwrite),
    .paddr       (paddr),
    .pwdata      (pwdata),
    .prdata      (prdata),
    .pready      (pready),
    .gain_o      (gain),
    .min_total_o (min_total)
  );

  trhf_charge #(.TICK_BITS(TICK_BITS)) u_charge (
    .clk_i       (clk_i),
    .rst_ni      (rst_ni),
    .in_valid_i  (in_valid_i),
    .in_ready_o  (in_ready_o),
    .in_item_i   (in_item_i),
    .gain_i      (gain),
    .out_valid_o (ch_valid),
    .out_ready_i (ch_ready),
    .out_o       (ch_item)
  );

  trhf_run #(.TICK_BITS(TICK_BITS)) u_run (
    .clk_i       (clk_i),
    .rst_ni      (rst_ni),
    .in_valid_i  (ch_valid),
    .in_ready_o  (ch_ready),
    .in_i        (ch_item),
    .min_total_i (min_total),
    .room_i      (room),
    .push_o      (push)
  );

  trhf_hit_fifo u_hit_fifo (
    .clk_i       (clk_i),
    .rst_ni      (rst_ni),
    .push_i      (push),
    .room_o      (room),
    .out_valid_o (out_valid_o),
    .out_ready_i (out_ready_i),
    .out_hit_o   (out_hit_o)
  );

endmodule

[rtl/trhf_regs.sv]
module trhf_regs (
  input  logic                             clk_i,
  input  logic                             rst_ni,
  input  logic                             psel,
  input  logic                             penable,
  input  logic                             pwrite,
  input  logic [trhf_pkg::ApbAddrW-1:0]    paddr,
  input  logic [trhf_pkg::ApbDataW-1:0]    pwdata,
  output logic [trhf_pkg::ApbDataW-1:0]    prdata,
  output logic                             pready,
  output logic [trhf_pkg::GainW-1:0]       gain_o,
  output logic [trhf_pkg::ThrW-1:0]        min_total_o
);
  import trhf_pkg::*;

  logic [GainW-1:0] gain_q, gain_d;
  logic [ThrW-1:0]  thr_q, thr_d;
  logic             wr_en;
  logic             reg_idx;

  assign pready  = 1'b1;
  assign wr_en   = psel & penable & pwrite;
  assign reg_idx = paddr[3];

  always_comb begin
    gain_d = gain_q;
    thr_d  = thr_q;
    prdata = '0;
    unique case (reg_idx)
      RegAdcGain: begin
        prdata = ApbDataW'(gain_q);
        if (wr_en) gain_d = pwdata[GainW-1:0];
      end
      RegMinTotal: begin
        prdata = ApbDataW'(thr_q);
        if (wr_en) thr_d = pwdata[ThrW-1:0];
      end
      default: prdata = '0;
    endcase
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      gain_q <= GainReset;
      thr_q  <= ThrReset;
    end else begin
      gain_q <= gain_d;
      thr_q  <= thr_d;
    end
  end

  assign gain_o      = gain_q;
  assign min_total_o = thr_q;

endmodule

[rtl/trhf_charge.sv]
module trhf_charge #(
  parameter int unsigned TICK_BITS = 16
) (
  input  logic                          clk_i,
  input  logic                          rst_ni,
  input  logic                          in_valid_i,
  output logic                          in_ready_o,
  input  trhf_pkg::tick_item_t          in_item_i,
  input  logic [trhf_pkg::GainW-1:0]    gain_i,
  output logic                          out_valid_o,
  input  logic                          out_ready_i,
  output trhf_pkg::charged_tick_t       out_o
);
  import trhf_pkg::*;

  localparam int unsigned ProdW = ElecW + GainW;

  logic          s1_valid_q, s1_valid_d;
  tick_item_t    s1_item_q, s1_item_d;
  logic          s2_valid_q, s2_valid_d;
  charged_tick_t s2_q;
  logic          s1_ready, s2_ready;
  logic [ProdW-1:0] product;
  logic [TICK_BITS-1:0] tick_in;

  assign s2_ready   = !s2_valid_q || out_ready_i;
  assign s1_ready   = !s1_valid_q || s2_ready;
  assign in_ready_o = s1_ready;

  assign tick_in = in_item_i.tick[TICK_BITS-1:0];
  assign product = ProdW'(s1_item_q.electrons) * ProdW'(gain_i);

  always_comb begin
    s1_item_d      = in_item_i;
    s1_item_d.tick = TickW'(tick_in);
  end

  always_comb begin
    s1_valid_d = s1_valid_q;
    s2_valid_d = s2_valid_q;
    if (s1_ready) s1_valid_d = in_valid_i;
    if (s2_ready) s2_valid_d = s1_valid_q;
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      s1_valid_q <= 1'b0;
      s2_valid_q <= 1'b0;
    end else begin
      s1_valid_q <= s1_valid_d;
      s2_valid_q <= s2_valid_d;
    end
  end

  always_ff @(posedge clk_i) begin
    if (s1_ready && in_valid_i) begin
      s1_item_q <= s1_item_d;
    end
    if (s2_ready && s1_valid_q) begin
      s2_q <= '{item: s1_item_q, charge: product[GainFrac +: ChargeW]};
    end
  end

  assign out_valid_o = s2_valid_q;
  assign out_o       = s2_q;

endmodule

[rtl/trhf_run.sv]
module trhf_run #(
  parameter int unsigned TICK_BITS = 16
) (
  input  logic                       clk_i,
  input  logic                       rst_ni,
  input  logic                       in_valid_i,
  output logic                       in_ready_o,
  input  trhf_pkg::charged_tick_t    in_i,
  input  logic [trhf_pkg::ThrW-1:0]  min_total_i,
  input  logic                       room_i,
  output trhf_pkg::hit_push_t        push_o
);
  import trhf_pkg::*;

  logic                  open_q, open_d;
  logic [TICK_BITS-1:0]  prev_q, prev_d;
  logic [TICK_BITS-1:0]  start_q, start_d;
  logic [TICK_BITS-1:0]  peak_tick_q, peak_tick_d;
  logic [ChargeW-1:0]    peak_q, peak_d;
  logic [TotalW-1:0]     total_q, total_d;
  logic [ChanW-1:0]      chan_q, chan_d;

  logic [TICK_BITS-1:0]  tick;
  logic [ChanW-1:0]      chan;
  logic [ChargeW-1:0]    charge;
  logic                  last;
  logic                  fire;
  logic                  gap;
  logic                  extend;
  logic [TotalW:0]       sum;
  logic [TotalW-1:0]     thr_wide;
  logic                  pass_gap, pass_last;
  hit_t                  hit_gap, hit_last;

  assign tick   = in_i.item.tick[TICK_BITS-1:0];
  assign chan   = in_i.item.channel_id;
  assign charge = in_i.charge;
  assign last   = in_i.item.end_of_channel;

  assign fire       = in_valid_i && room_i;
  assign in_ready_o = room_i;

  // A larger step than one tick, or a new channel, ends the open run first.
  assign gap = open_q && ((chan != chan_q) ||
               ((TICK_BITS + 1)'(tick) > (TICK_BITS + 1)'(prev_q) + 1'b1));
  assign extend = open_q && !gap;

  assign sum      = (TotalW + 1)'(total_q) + (TotalW + 1)'(charge);
  assign thr_wide = TotalW'(min_total_i);

  always_comb begin
    chan_d      = chan_q;
    start_d     = start_q;
    peak_tick_d = peak_tick_q;
    peak_d      = peak_q;
    total_d     = total_q;
    prev_d      = tick;
    if (extend) begin
      if (charge > peak_q) begin
        peak_d      = charge;
        peak_tick_d = tick;
      end
      total_d = sum[TotalW] ? '1 : sum[TotalW-1:0];
    end else begin
      chan_d      = chan;
      start_d     = tick;
      peak_tick_d = tick;
      peak_d      = charge;
      total_d     = TotalW'(charge);
    end
    open_d = !last;
  end

  always_comb begin
    hit_gap.hit_channel     = chan_q;
    hit_gap.start_tick      = TickW'(start_q);
    hit_gap.stop_tick       = TickW'(prev_q);
    hit_gap.peak_tick       = TickW'(peak_tick_q);
    hit_gap.peak_charge_q8  = peak_q;
    hit_gap.total_charge_q8 = total_q;
    hit_gap.final_of_step   = 1'b0;

    hit_last.hit_channel     = chan_d;
    hit_last.start_tick      = TickW'(start_d);
    hit_last.stop_tick       = TickW'(tick);
    hit_last.peak_tick       = TickW'(peak_tick_d);
    hit_last.peak_charge_q8  = peak_d;
    hit_last.total_charge_q8 = total_d;
    hit_last.final_of_step   = 1'b1;

    pass_gap  = gap && (total_q > thr_wide);
    pass_last = last && (total_d > thr_wide);

    push_o.second = hit_last;
    if (pass_gap) begin
      push_o.first = hit_gap;
      push_o.first.final_of_step = !pass_last;
    end else begin
      push_o.first = hit_last;
    end
    push_o.count = 2'd0;
    if (fire) push_o.count = 2'(pass_gap) + 2'(pass_last);
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      open_q      <= 1'b0;
      prev_q      <= '0;
      start_q     <= '0;
      peak_tick_q <= '0;
      peak_q      <= '0;
      total_q     <= '0;
      chan_q      <= '0;
    end else if (fire) begin
      open_q      <= open_d;
      prev_q      <= prev_d;
      start_q     <= start_d;
      peak_tick_q <= peak_tick_d;
      peak_q      <= peak_d;
      total_q     <= total_d;
      chan_q      <= chan_d;
    end
  end

endmodule

[rtl/trhf_hit_fifo.sv]
module trhf_hit_fifo (
  input  logic                 clk_i,
  input  logic                 rst_ni,
  input  trhf_pkg::hit_push_t  push_i,
  output logic                 room_o,
  output logic                 out_valid_o,
  input  logic                 out_ready_i,
  output trhf_pkg::hit_t       out_hit_o
);
  import trhf_pkg::*;

  localparam int unsigned Depth = 4;
  localparam int unsigned PtrW  = $clog2(Depth);
  localparam int unsigned CntW  = PtrW + 1;

  hit_t            mem_q [Depth];
  logic [PtrW-1:0] wr_q, wr_d, rd_q, rd_d;
  logic [CntW-1:0] cnt_q, cnt_d;
  logic            pop;
  logic [PtrW-1:0] wr_next;

  // Room for the worst case of two hits from one tick.
  assign room_o      = cnt_q <= CntW'(Depth - 2);
  assign out_valid_o = cnt_q != '0;
  assign out_hit_o   = mem_q[rd_q];
  assign pop         = out_valid_o && out_ready_i;
  assign wr_next     = wr_q + 1'b1;

  always_comb begin
    wr_d  = wr_q + PtrW'(push_i.count);
    rd_d  = pop ? rd_q + 1'b1 : rd_q;
    cnt_d = cnt_q + CntW'(push_i.count) - CntW'(pop);
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      wr_q  <= '0;
      rd_q  <= '0;
      cnt_q <= '0;
    end else begin
      wr_q  <= wr_d;
      rd_q  <= rd_d;
      cnt_q <= cnt_d;
    end
  end

  always_ff @(posedge clk_i) begin
    if (push_i.count != 2'd0) mem_q[wr_q] <= push_i.first;
    if (push_i.count == 2'd2) mem_q[wr_next] <= push_i.second;
  end

endmodule
